/* rtl/rtt_pkg.sv */
// Shared types and constants of the RSI threshold trader.
package rtt_pkg;

    localparam int RSI_BITS       = 15;
    localparam int CASH_BITS      = 48;
    localparam int POS_BITS       = 11;
    localparam int LIMIT_BITS     = 10;
    localparam int LEVEL_BITS     = 15;
    localparam int WIN_FIELD_BITS = 7;
    localparam int CFG_DATA_BITS  = 15;
    localparam int CFG_IDX_BITS   = 2;
    localparam int DIV_CNT_BITS   = 4;

    localparam logic [RSI_BITS-1:0] RSI_FULL = 15'd25600;

    localparam logic [WIN_FIELD_BITS-1:0] WIN_RESET   = 7'd14;
    localparam logic [LIMIT_BITS-1:0]     LIMIT_RESET = 10'd1;
    localparam logic [LEVEL_BITS-1:0]     OVERSOLD_RESET   = 15'd7680;
    localparam logic [LEVEL_BITS-1:0]     OVERBOUGHT_RESET = 15'd17920;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OVERSOLD   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OVERBOUGHT = 2'd3;

    typedef struct packed {
        logic capture;
        logic add_change;
        logic rd_next;
        logic take_oldest;
        logic sub_change;
        logic commit;
        logic calc;
        logic div_start;
        logic buy;
        logic sell;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic ready;
        logic total_zero;
        logic div_done;
    } stat_t;

endpackage

/* rtl/rtt_ctrl.sv */
// Sequencing state machine of the RSI threshold trader.
module rtt_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  rtt_pkg::stat_t stat,
    output rtt_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADD   = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_RD2   = 4'd3;
    localparam logic [3:0] S_CALC  = 4'd4;
    localparam logic [3:0] S_DIVGO = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_BUY   = 4'd7;
    localparam logic [3:0] S_SELL  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.add_change = 1'b1;
                state_next     = S_RD1;
            end
            S_RD1:
            begin
                cmd.take_oldest = 1'b1;
                cmd.rd_next     = 1'b1;
                state_next      = S_RD2;
            end
            S_RD2:
            begin
                cmd.sub_change = 1'b1;
                cmd.commit     = 1'b1;
                state_next     = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc = 1'b1;
                if (stat.ready && !stat.total_zero)
                    state_next = S_DIVGO;
                else
                    state_next = S_DONE;
            end
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_BUY;
            end
            S_BUY:
            begin
                cmd.buy    = 1'b1;
                state_next = S_SELL;
            end
            S_SELL:
            begin
                cmd.sell   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/rtt_div.sv */
// Restoring divider, one quotient bit per cycle, for the RSI value.
module rtt_div #(
    parameter int SUM_BITS = 31
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [SUM_BITS+rtt_pkg::RSI_BITS-1:0] dividend,
    input  logic [SUM_BITS:0]                     divisor,
    output logic                                  done,
    output logic [rtt_pkg::RSI_BITS-1:0]          quotient
);

    localparam int QB = rtt_pkg::RSI_BITS;

    logic                              busy_reg;
    logic                              done_reg;
    logic [rtt_pkg::DIV_CNT_BITS-1:0]  cnt_reg;
    logic [SUM_BITS:0]                 rem_reg;
    logic [SUM_BITS:0]                 dsr_reg;
    logic [QB-1:0]                     dvd_reg;
    logic [QB-1:0]                     quo_reg;
    logic [SUM_BITS+1:0]               shifted;
    logic [SUM_BITS+1:0]               diff;
    logic                              fits;

    // dividend < 2^QB * divisor, so the top part is already below the divisor
    assign shifted = {rem_reg, dvd_reg[QB-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = (shifted >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= rtt_pkg::DIV_CNT_BITS'(QB);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == rtt_pkg::DIV_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, dividend[SUM_BITS+QB-1:QB]};
            dvd_reg <= dividend[QB-1:0];
            dsr_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[SUM_BITS:0] : shifted[SUM_BITS:0];
            dvd_reg <= {dvd_reg[QB-2:0], 1'b0};
            quo_reg <= {quo_reg[QB-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/rtt_dp.sv */
// Datapath: price ring, gain and loss sums, RSI, position and cash.
module rtt_dp #(
    parameter int WINDOW_MAX = 64,
    parameter int PRICE_BITS = 24
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rtt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [rtt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [PRICE_BITS-1:0]               close_price,
    input  rtt_pkg::cmd_t                       cmd,
    output rtt_pkg::stat_t                      stat,
    output logic                                rsi_ready,
    output logic                                rsi_undefined,
    output logic [rtt_pkg::RSI_BITS-1:0]        rsi_value,
    output logic                                bought,
    output logic                                sold,
    output logic signed [rtt_pkg::POS_BITS-1:0] held_units,
    output logic signed [rtt_pkg::CASH_BITS-1:0] cash_balance
);

    localparam int PTR_BITS  = $clog2(WINDOW_MAX + 1);
    localparam int CNT_BITS  = PTR_BITS + 1;
    localparam int DEPTH     = WINDOW_MAX + 1;
    localparam int SUM_BITS  = PRICE_BITS + PTR_BITS;
    localparam int PROD_BITS = SUM_BITS + rtt_pkg::RSI_BITS;
    localparam int CB        = rtt_pkg::CASH_BITS;
    localparam int PB        = rtt_pkg::POS_BITS;
    localparam int WIN_RST   = (int'(rtt_pkg::WIN_RESET) > WINDOW_MAX) ? WINDOW_MAX
                                                                     : int'(rtt_pkg::WIN_RESET);

    logic [PTR_BITS-1:0]                window_reg;
    logic [rtt_pkg::LIMIT_BITS-1:0]     limit_reg;
    logic [rtt_pkg::LEVEL_BITS-1:0]     oversold_reg;
    logic [rtt_pkg::LEVEL_BITS-1:0]     overbought_reg;
    logic [PTR_BITS-1:0]                win_cfg;
    logic [rtt_pkg::WIN_FIELD_BITS-1:0] win_field;
    logic                               win_write;

    logic [PRICE_BITS-1:0]              ring_mem [DEPTH];
    logic [PRICE_BITS-1:0]              rd_data_reg;
    logic [PTR_BITS-1:0]                rd_addr;

    logic [PTR_BITS-1:0]                ptr_reg;
    logic [PTR_BITS-1:0]                next_ptr;
    logic [CNT_BITS-1:0]                ptr_inc;
    logic [CNT_BITS-1:0]                slots;
    logic [CNT_BITS-1:0]                seen_reg;
    logic                               full;

    logic [PRICE_BITS-1:0]              price_reg;
    logic [PRICE_BITS-1:0]              last_price_reg;
    logic [PRICE_BITS-1:0]              oldest_reg;
    logic [PRICE_BITS-1:0]              older;
    logic [PRICE_BITS-1:0]              newer;
    logic                               up;
    logic [SUM_BITS-1:0]                diff;
    logic                               apply;

    logic [SUM_BITS-1:0]                gain_reg;
    logic [SUM_BITS-1:0]                loss_reg;
    logic [PROD_BITS-1:0]               prod_reg;
    logic [SUM_BITS:0]                  total_reg;
    logic                               div_done;
    logic [rtt_pkg::RSI_BITS-1:0]       quotient;

    logic                               ready_reg;
    logic                               undef_reg;
    logic [rtt_pkg::RSI_BITS-1:0]       rsi_reg;
    logic                               bought_reg;
    logic                               sold_reg;
    logic signed [PB-1:0]               pos_reg;
    logic signed [CB-1:0]               cash_reg;
    logic signed [PB-1:0]               lim_pos;
    logic signed [PB-1:0]               lim_neg;
    logic                               buy_ok;
    logic                               sell_ok;
    logic [CB:0]                        cash_ext;
    logic [CB:0]                        price_ext;
    logic [CB:0]                        cash_sum;
    logic [CB-1:0]                      cash_sat;

    logic                               out_ready_reg;
    logic                               out_undef_reg;
    logic [rtt_pkg::RSI_BITS-1:0]       out_rsi_reg;
    logic                               out_bought_reg;
    logic                               out_sold_reg;
    logic signed [PB-1:0]               out_pos_reg;
    logic signed [CB-1:0]               out_cash_reg;

    // window write: zero acts as one, a value above WINDOW_MAX acts as WINDOW_MAX
    assign win_field = cfg_data[rtt_pkg::WIN_FIELD_BITS-1:0];
    assign win_write = cfg_we && (cfg_index == rtt_pkg::REG_WINDOW);

    always_comb
    begin
        if (win_field == '0)
            win_cfg = PTR_BITS'(1);
        else if ({25'd0, win_field} > WINDOW_MAX)
            win_cfg = PTR_BITS'(WINDOW_MAX);
        else
            win_cfg = PTR_BITS'(win_field);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= PTR_BITS'(WIN_RST);
            limit_reg      <= rtt_pkg::LIMIT_RESET;
            oversold_reg   <= rtt_pkg::OVERSOLD_RESET;
            overbought_reg <= rtt_pkg::OVERBOUGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rtt_pkg::REG_WINDOW:     window_reg     <= win_cfg;
                rtt_pkg::REG_LIMIT:      limit_reg      <= cfg_data[rtt_pkg::LIMIT_BITS-1:0];
                rtt_pkg::REG_OVERSOLD:   oversold_reg   <= cfg_data;
                rtt_pkg::REG_OVERBOUGHT: overbought_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign slots    = {1'b0, window_reg} + 1'b1;
    assign ptr_inc  = {1'b0, ptr_reg} + 1'b1;
    assign next_ptr = (ptr_inc == slots) ? '0 : ptr_inc[PTR_BITS-1:0];
    assign full     = (seen_reg >= slots);
    assign rd_addr  = cmd.rd_next ? next_ptr : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            ring_mem[ptr_reg] <= price_reg;
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            price_reg <= close_price;
        if (cmd.take_oldest)
            oldest_reg <= rd_data_reg;
        if (cmd.commit)
            last_price_reg <= price_reg;
    end

    // newest change enters the sums, the oldest one leaves them
    assign older = cmd.sub_change ? oldest_reg  : last_price_reg;
    assign newer = cmd.sub_change ? rd_data_reg : price_reg;
    assign up    = (newer > older);
    assign diff  = SUM_BITS'(up ? (newer - older) : (older - newer));
    assign apply = (cmd.add_change && (seen_reg != '0)) || (cmd.sub_change && full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            seen_reg <= '0;
            gain_reg <= '0;
            loss_reg <= '0;
        end
        else if (win_write)
        begin
            ptr_reg  <= '0;
            seen_reg <= '0;
            gain_reg <= '0;
            loss_reg <= '0;
        end
        else
        begin
            if (apply)
            begin
                if (up)
                    gain_reg <= cmd.sub_change ? gain_reg - diff : gain_reg + diff;
                else
                    loss_reg <= cmd.sub_change ? loss_reg - diff : loss_reg + diff;
            end
            if (cmd.commit)
            begin
                ptr_reg <= next_ptr;
                if (seen_reg < slots)
                    seen_reg <= seen_reg + 1'b1;
            end
        end
    end

    // 25600 = 2^14 + 2^13 + 2^10
    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            prod_reg  <= (PROD_BITS'(gain_reg) << 14) + (PROD_BITS'(gain_reg) << 13)
                       + (PROD_BITS'(gain_reg) << 10);
            total_reg <= {1'b0, gain_reg} + {1'b0, loss_reg};
        end
    end

    rtt_div #(
        .SUM_BITS (SUM_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign stat.ready      = full;
    assign stat.total_zero = (gain_reg == '0) && (loss_reg == '0);
    assign stat.div_done   = div_done;

    assign lim_pos = PB'({1'b0, limit_reg});
    assign lim_neg = PB'(0) - lim_pos;
    assign buy_ok  = (rsi_reg <= oversold_reg) && (pos_reg < lim_pos);
    assign sell_ok = (rsi_reg >= overbought_reg) && (pos_reg > lim_neg);

    assign cash_ext  = {cash_reg[CB-1], cash_reg};
    assign price_ext = (CB + 1)'(price_reg);
    assign cash_sum  = cmd.buy ? (cash_ext - price_ext) : (cash_ext + price_ext);

    always_comb
    begin
        if (cash_sum[CB] != cash_sum[CB-1])
            cash_sat = cash_sum[CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
        else
            cash_sat = cash_sum[CB-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            ready_reg  <= full;
            undef_reg  <= full && stat.total_zero;
            rsi_reg    <= '0;
            bought_reg <= 1'b0;
            sold_reg   <= 1'b0;
        end
        else
        begin
            if (div_done)
                rsi_reg <= quotient;
            if (cmd.buy && buy_ok)
                bought_reg <= 1'b1;
            if (cmd.sell && sell_ok)
                sold_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            cash_reg <= '0;
        end
        else if (cmd.buy && buy_ok)
        begin
            pos_reg  <= pos_reg + 1'b1;
            cash_reg <= cash_sat;
        end
        else if (cmd.sell && sell_ok)
        begin
            pos_reg  <= pos_reg - 1'b1;
            cash_reg <= cash_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_ready_reg  <= ready_reg;
            out_undef_reg  <= undef_reg;
            out_rsi_reg    <= rsi_reg;
            out_bought_reg <= bought_reg;
            out_sold_reg   <= sold_reg;
            out_pos_reg    <= pos_reg;
            out_cash_reg   <= cash_reg;
        end
    end

    assign rsi_ready     = out_ready_reg;
    assign rsi_undefined = out_undef_reg;
    assign rsi_value     = out_rsi_reg;
    assign bought        = out_bought_reg;
    assign sold          = out_sold_reg;
    assign held_units    = out_pos_reg;
    assign cash_balance  = out_cash_reg;

endmodule

/* rtl/rsi_threshold_trader.sv */
// Top level of the RSI threshold trader: controller, datapath and ports.
// The RSI divider is skipped when RSI is not formed; otherwise its 15 steps run per request.
// A new request is taken only after the previous result is loaded into the output register.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n low, asynchronous) clears sums, pointer, count, position and cash and
// loads the register defaults; ring entries are written before they are read.
module rsi_threshold_trader #(
    parameter int WINDOW_MAX = 64,
    parameter int PRICE_BITS = 24
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rtt_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [rtt_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [PRICE_BITS-1:0]                 close_price,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  rsi_ready,
    output logic                                  rsi_undefined,
    output logic [rtt_pkg::RSI_BITS-1:0]          rsi_value,
    output logic                                  bought,
    output logic                                  sold,
    output logic signed [rtt_pkg::POS_BITS-1:0]   held_units,
    output logic signed [rtt_pkg::CASH_BITS-1:0]  cash_balance
);

    rtt_pkg::cmd_t  cmd;
    rtt_pkg::stat_t stat;

    rtt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rtt_dp #(
        .WINDOW_MAX (WINDOW_MAX),
        .PRICE_BITS (PRICE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .close_price   (close_price),
        .cmd           (cmd),
        .stat          (stat),
        .rsi_ready     (rsi_ready),
        .rsi_undefined (rsi_undefined),
        .rsi_value     (rsi_value),
        .bought        (bought),
        .sold          (sold),
        .held_units    (held_units),
        .cash_balance  (cash_balance)
    );

endmodule

/* rtl/rtt_chk.sv */
// Port-level checks of the RSI threshold trader and their bind.
module rtt_chk
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic                                  rsi_ready,
    input logic                                  rsi_undefined,
    input logic [rtt_pkg::RSI_BITS-1:0]          rsi_value,
    input logic                                  bought,
    input logic                                  sold,
    input logic signed [rtt_pkg::POS_BITS-1:0]   held_units,
    input logic signed [rtt_pkg::CASH_BITS-1:0]  cash_balance
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cash_balance) && $stable(held_units))
        else $error("result changed while stalled");

    // one request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    a_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rsi_ready |-> !rsi_undefined && !bought && !sold && (rsi_value == '0))
        else $error("trade or RSI before window filled");

    a_undef: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rsi_undefined |-> rsi_ready && !bought && !sold && (rsi_value == '0))
        else $error("trade on undefined RSI");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rsi_value <= rtt_pkg::RSI_FULL)
        else $error("RSI above full scale");

endmodule

bind rsi_threshold_trader rtt_chk u_rtt_chk (.*);
